// ===== hdl/tid_pkg.sv =====
// Package for the Thumb instruction decoder: operation codes, pattern kinds and
// the priority-ordered mask/match table used by the classifier.
// It depends on nothing else.
`default_nettype none

package tid_pkg;

    localparam int InstrWidth = 16;
    localparam int OpWidth = 7;
    localparam int PatternCount = 73;

    typedef logic [InstrWidth-1:0] t_instr;
    typedef logic [OpWidth-1:0] t_op;

    localparam t_op OPC_BEQ = 7'd11;
    localparam t_op OPC_BL = 7'd28;
    localparam t_op OPC_BLX_THUMB = 7'd29;
    localparam t_op OPC_BLX_ARM = 7'd30;
    localparam t_op OPC_INVALID = 7'd88;

    localparam logic [3:0] CondLast = 4'd13;

    localparam logic [1:0] BLSEL_BLX_ARM = 2'd1;
    localparam logic [1:0] BLSEL_BL = 2'd2;
    localparam logic [1:0] BLSEL_BLX_THUMB = 2'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PLAIN = 2'd0;
    localparam t_kind KIND_ADD1 = 2'd1;
    localparam t_kind KIND_BCOND = 2'd2;
    localparam t_kind KIND_BLPFX = 2'd3;

    typedef struct packed {
        t_instr mask;
        t_instr match;
        t_kind  kind;
        t_op    code;
    } t_pattern;

    // The first entry that matches decides the result.
    localparam t_pattern PATTERNS [PatternCount] = '{
        '{16'hFFC0, 16'h4140, KIND_PLAIN, 7'd0},
        '{16'hFE00, 16'h1C00, KIND_ADD1,  7'd1},
        '{16'hF800, 16'h3000, KIND_PLAIN, 7'd2},
        '{16'hFE00, 16'h1800, KIND_PLAIN, 7'd3},
        '{16'hFF00, 16'h4400, KIND_PLAIN, 7'd4},
        '{16'hF800, 16'hA000, KIND_PLAIN, 7'd5},
        '{16'hF800, 16'hA800, KIND_PLAIN, 7'd6},
        '{16'hFF80, 16'hB000, KIND_PLAIN, 7'd7},
        '{16'hFFC0, 16'h4000, KIND_PLAIN, 7'd8},
        '{16'hF800, 16'h1000, KIND_PLAIN, 7'd9},
        '{16'hFFC0, 16'h4100, KIND_PLAIN, 7'd10},
        '{16'hF000, 16'hD000, KIND_BCOND, OPC_BEQ},
        '{16'hF800, 16'hE000, KIND_PLAIN, 7'd25},
        '{16'hFFC0, 16'h4380, KIND_PLAIN, 7'd26},
        '{16'hFF00, 16'hBE00, KIND_PLAIN, 7'd27},
        '{16'hE000, 16'hE000, KIND_BLPFX, OPC_BL},
        '{16'hFF87, 16'h4780, KIND_PLAIN, 7'd31},
        '{16'hFF87, 16'h4700, KIND_PLAIN, 7'd32},
        '{16'hFFC0, 16'h42C0, KIND_PLAIN, 7'd33},
        '{16'hF800, 16'h2800, KIND_PLAIN, 7'd34},
        '{16'hFFC0, 16'h4280, KIND_PLAIN, 7'd35},
        '{16'hFF00, 16'h4500, KIND_PLAIN, 7'd36},
        '{16'hFFE8, 16'hB660, KIND_PLAIN, 7'd37},
        '{16'hFFC0, 16'h4600, KIND_PLAIN, 7'd38},
        '{16'hFFC0, 16'h4040, KIND_PLAIN, 7'd39},
        '{16'hF800, 16'hC800, KIND_PLAIN, 7'd40},
        '{16'hF800, 16'h6800, KIND_PLAIN, 7'd41},
        '{16'hFE00, 16'h5800, KIND_PLAIN, 7'd42},
        '{16'hF800, 16'h4800, KIND_PLAIN, 7'd43},
        '{16'hF800, 16'h9800, KIND_PLAIN, 7'd44},
        '{16'hF800, 16'h7800, KIND_PLAIN, 7'd45},
        '{16'hFE00, 16'h5C00, KIND_PLAIN, 7'd46},
        '{16'hF800, 16'h8800, KIND_PLAIN, 7'd47},
        '{16'hFE00, 16'h5A00, KIND_PLAIN, 7'd48},
        '{16'hFE00, 16'h5600, KIND_PLAIN, 7'd49},
        '{16'hFE00, 16'h5E00, KIND_PLAIN, 7'd50},
        '{16'hF800, 16'h0000, KIND_PLAIN, 7'd51},
        '{16'hFFC0, 16'h4080, KIND_PLAIN, 7'd52},
        '{16'hF800, 16'h0800, KIND_PLAIN, 7'd53},
        '{16'hFFC0, 16'h40C0, KIND_PLAIN, 7'd54},
        '{16'hF800, 16'h2000, KIND_PLAIN, 7'd55},
        '{16'hFFC0, 16'h1C00, KIND_PLAIN, 7'd56},
        '{16'hFF00, 16'h4600, KIND_PLAIN, 7'd57},
        '{16'hFFC0, 16'h4340, KIND_PLAIN, 7'd58},
        '{16'hFFC0, 16'h43C0, KIND_PLAIN, 7'd59},
        '{16'hFFC0, 16'h4240, KIND_PLAIN, 7'd60},
        '{16'hFFC0, 16'h4300, KIND_PLAIN, 7'd61},
        '{16'hFE00, 16'hBC00, KIND_PLAIN, 7'd62},
        '{16'hFE00, 16'hB400, KIND_PLAIN, 7'd63},
        '{16'hFFC0, 16'hBA00, KIND_PLAIN, 7'd64},
        '{16'hFFC0, 16'hBA40, KIND_PLAIN, 7'd65},
        '{16'hFFC0, 16'hBAC0, KIND_PLAIN, 7'd66},
        '{16'hFFC0, 16'h41C0, KIND_PLAIN, 7'd67},
        '{16'hFFC0, 16'h4180, KIND_PLAIN, 7'd68},
        '{16'hFFF7, 16'hB650, KIND_PLAIN, 7'd69},
        '{16'hF800, 16'hC000, KIND_PLAIN, 7'd70},
        '{16'hF800, 16'h6000, KIND_PLAIN, 7'd71},
        '{16'hFE00, 16'h5000, KIND_PLAIN, 7'd72},
        '{16'hF800, 16'h9000, KIND_PLAIN, 7'd73},
        '{16'hF800, 16'h7000, KIND_PLAIN, 7'd74},
        '{16'hFE00, 16'h5400, KIND_PLAIN, 7'd75},
        '{16'hF800, 16'h8000, KIND_PLAIN, 7'd76},
        '{16'hFE00, 16'h5200, KIND_PLAIN, 7'd77},
        '{16'hFE00, 16'h1E00, KIND_PLAIN, 7'd78},
        '{16'hF800, 16'h3800, KIND_PLAIN, 7'd79},
        '{16'hFE00, 16'h1A00, KIND_PLAIN, 7'd80},
        '{16'hFF80, 16'hB080, KIND_PLAIN, 7'd81},
        '{16'hFF00, 16'hDF00, KIND_PLAIN, 7'd82},
        '{16'hFFC0, 16'hB240, KIND_PLAIN, 7'd83},
        '{16'hFFC0, 16'hB200, KIND_PLAIN, 7'd84},
        '{16'hFFC0, 16'h4200, KIND_PLAIN, 7'd85},
        '{16'hFFC0, 16'hB2C0, KIND_PLAIN, 7'd86},
        '{16'hFFC0, 16'hB280, KIND_PLAIN, 7'd87}
    };

endpackage

`default_nettype wire

// ===== hdl/tid_decode.sv =====
// Combinational classifier: matches one Thumb halfword against the priority
// table and resolves the branch groups. Depends on tid_pkg.
`default_nettype none

module tid_decode (
    input  wire tid_pkg::t_instr i_instr,
    output tid_pkg::t_op         o_op_code,
    output logic                 o_is_invalid
);

    logic [tid_pkg::PatternCount-1:0] hit;
    tid_pkg::t_op bcond_op;
    tid_pkg::t_op blpfx_op;
    tid_pkg::t_op op;

    always_comb begin
        for (int i = 0; i < tid_pkg::PatternCount; i++) begin
            hit[i] = ((i_instr & tid_pkg::PATTERNS[i].mask) == tid_pkg::PATTERNS[i].match)
                && !((tid_pkg::PATTERNS[i].kind == tid_pkg::KIND_ADD1)
                     && (i_instr[8:6] == 3'd0));
        end
    end

    always_comb begin
        if (i_instr[11:8] <= tid_pkg::CondLast) begin
            bcond_op = tid_pkg::OPC_BEQ + {3'd0, i_instr[11:8]};
        end else begin
            bcond_op = tid_pkg::OPC_INVALID;
        end
    end

    always_comb begin
        case (i_instr[12:11])
            tid_pkg::BLSEL_BL:        blpfx_op = tid_pkg::OPC_BL;
            tid_pkg::BLSEL_BLX_THUMB: blpfx_op = tid_pkg::OPC_BLX_THUMB;
            tid_pkg::BLSEL_BLX_ARM:   blpfx_op = tid_pkg::OPC_BLX_ARM;
            default:                  blpfx_op = tid_pkg::OPC_INVALID;
        endcase
    end

    // Scanning from the end lets the earliest matching entry win.
    always_comb begin
        op = tid_pkg::OPC_INVALID;
        for (int i = tid_pkg::PatternCount - 1; i >= 0; i--) begin
            if (hit[i]) begin
                case (tid_pkg::PATTERNS[i].kind)
                    tid_pkg::KIND_BCOND: op = bcond_op;
                    tid_pkg::KIND_BLPFX: op = blpfx_op;
                    default:             op = tid_pkg::PATTERNS[i].code;
                endcase
            end
        end
    end

    assign o_op_code = op;
    assign o_is_invalid = (op == tid_pkg::OPC_INVALID);

endmodule

`default_nettype wire

// ===== hdl/thumb_instruction_decoder_top.sv =====
// Top level of the Thumb instruction decoder: input register, classifier and
// result register with stream handshakes. Depends on tid_pkg and tid_decode.
//
// The slave channel takes one 16-bit Thumb halfword per item. The master
// channel returns one item per input item: the operation number in tdata and
// an invalid flag in tuser. Operation numbers follow the instruction list
// order, and the value 88 marks an instruction that does not decode.
// An item accepted at a clock edge is held in the input register, decoded
// combinationally from it and shown on the master side once the result
// register takes it. One item is accepted in every cycle as long as the
// receiver keeps tready high; the throughput is one item per cycle and is
// set by the single decode stage between the two registers.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more item, so the slave side drops tready only once both
// are full. Synchronous reset empties both registers and no item is shown.
`default_nettype none

module thumb_instruction_decoder_top (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire  [15:0]        i_s_axis_tdata,   // [15:0] instruction
    output logic               o_m_axis_tvalid,
    input  wire                i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,   // [6:0] op_code, [7] zero
    output logic               o_m_axis_tuser    // [0] is_invalid
);

    logic            r_in_valid;
    tid_pkg::t_instr r_in_instr;
    logic            r_out_valid;
    tid_pkg::t_op    r_out_op;
    logic            r_out_invalid;

    tid_pkg::t_op dec_op;
    logic         dec_invalid;
    logic         out_free;
    logic         in_take;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_take = i_s_axis_tvalid && o_s_axis_tready;

    tid_decode u_decode (
        .i_instr      (r_in_instr),
        .o_op_code    (dec_op),
        .o_is_invalid (dec_invalid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (in_take) begin
            r_in_instr <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (out_free && r_in_valid) begin
            r_out_op <= dec_op;
            r_out_invalid <= dec_invalid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {1'b0, r_out_op};
    assign o_m_axis_tuser = r_out_invalid;

endmodule

`default_nettype wire
